// ===== src/clsr_pkg.sv =====
// clsr_pkg: shared types, constants and digit/segment functions for the
// clock LED segment refresh unit. No dependencies.

package clsr_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_DIGITS  = 6;
    localparam int FRAME_COUNT = 9;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [7:0] FRAME_MODE      = 8'h02;
    localparam logic [7:0] FRAME_DATA_AUTO = 8'h40;
    localparam logic [7:0] FRAME_DISP_ON   = 8'h88;
    localparam logic [7:0] ADDR_BASE       = 8'hc0;
    localparam logic [7:0] SEG_DASH        = 8'h40;
    localparam logic [7:0] SEG_BLANK       = 8'h00;
    localparam logic [7:0] SEG_DOT         = 8'h80;
    localparam logic [7:0] LEVEL_MAX       = 8'h07;

    localparam logic [4:0] BITS_CMD  = 5'd8;
    localparam logic [4:0] BITS_DATA = 5'd16;

    localparam logic [0:0] ADDR_BRIGHTNESS = 1'b0;
    localparam logic [0:0] ADDR_FLIPPED    = 1'b1;

    // refresh transaction handed from front to back
    typedef struct packed {
        logic [NUM_DIGITS-1:0][7:0] data;
        logic [2:0]                 level;
    } refresh_t;

    typedef logic [7:0] digit_buf_t [NUM_DIGITS];

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'h3f;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5b;
            4'd3: s = 8'h4f;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6d;
            4'd6: s = 8'h7d;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7f;
            4'd9: s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // v/10 for v < 64 via reciprocal (13/128)
    function automatic logic [3:0] tens_digit(input logic [5:0] v);
        logic [9:0] p;
        p = 10'(v) * 10'd13;
        return p[9:7] == 3'd0 ? 4'd0 : 4'(p[9:7]);
    endfunction

    function automatic logic [3:0] units_digit(input logic [5:0] v);
        logic [5:0] t10;
        logic [5:0] r;
        t10 = 6'(tens_digit(v)) * 6'd10;
        r   = v - t10;
        return r[3:0];
    endfunction

    function automatic logic [7:0] swap_top(input logic [7:0] v);
        return {v[6], v[7], v[5:0]};
    endfunction

    function automatic logic [7:0] turn_over(input logic [7:0] v);
        return {v[6], v[7], v[2:0], v[5:3]};
    endfunction

endpackage

// ===== src/clsr_front.sv =====
// clsr_front: takes input transactions, updates the digit buffer on loads
// and builds the remapped refresh transaction on ticks. Uses clsr_pkg.

module clsr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic                 s_date_mode,
    input  logic [4:0]           s_hour_value,
    input  logic [5:0]           s_minute_value,
    input  logic [5:0]           s_second_value,
    input  logic [3:0]           s_month_value,
    input  logic [4:0]           s_day_value,
    input  logic [7:0]           brightness_level,
    input  logic                 flipped_view,
    input  logic                 q_full,
    output logic                 q_push,
    output clsr_pkg::refresh_t   q_data
);

    clsr_pkg::digit_buf_t buf_reg;
    clsr_pkg::digit_buf_t buf_next;
    logic                 accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (s_cmd == clsr_pkg::CMD_TICK);

    always_comb begin
        logic [5:0] h, m, s, mo, d;
        h  = 6'(s_hour_value);
        m  = s_minute_value;
        s  = s_second_value;
        mo = 6'(s_month_value);
        d  = 6'(s_day_value);
        buf_next = buf_reg;
        if (accept && s_cmd == clsr_pkg::CMD_LOAD) begin
            if (!s_date_mode) begin
                buf_next[0] = clsr_pkg::seg_code(clsr_pkg::tens_digit(h));
                buf_next[1] = clsr_pkg::seg_code(clsr_pkg::units_digit(h)) | clsr_pkg::SEG_DOT;
                buf_next[2] = clsr_pkg::seg_code(clsr_pkg::tens_digit(m)) | clsr_pkg::SEG_DOT;
                buf_next[3] = clsr_pkg::seg_code(clsr_pkg::units_digit(m)) | clsr_pkg::SEG_DOT;
                buf_next[4] = clsr_pkg::seg_code(clsr_pkg::tens_digit(s)) | clsr_pkg::SEG_DOT;
                buf_next[5] = clsr_pkg::seg_code(clsr_pkg::units_digit(s));
            end else begin
                buf_next[0] = clsr_pkg::SEG_BLANK;
                buf_next[1] = clsr_pkg::seg_code(clsr_pkg::tens_digit(mo));
                buf_next[2] = clsr_pkg::seg_code(clsr_pkg::units_digit(mo));
                buf_next[3] = clsr_pkg::SEG_DASH;
                buf_next[4] = clsr_pkg::seg_code(clsr_pkg::tens_digit(d));
                buf_next[5] = clsr_pkg::seg_code(clsr_pkg::units_digit(d));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < clsr_pkg::NUM_DIGITS; i++) begin
                buf_reg[i] <= clsr_pkg::SEG_DASH;
            end
        end else begin
            buf_reg <= buf_next;
        end
    end

    always_comb begin
        if (!flipped_view) begin
            q_data.data[0] = clsr_pkg::swap_top(buf_reg[5]);
            q_data.data[1] = clsr_pkg::swap_top(buf_reg[4]);
            q_data.data[2] = buf_reg[3];
            q_data.data[3] = clsr_pkg::swap_top(buf_reg[2]);
            q_data.data[4] = buf_reg[1];
            q_data.data[5] = buf_reg[0];
        end else begin
            q_data.data[0] = clsr_pkg::turn_over(buf_reg[0]);
            q_data.data[1] = clsr_pkg::turn_over(buf_reg[1]);
            q_data.data[2] = clsr_pkg::turn_over(clsr_pkg::swap_top(buf_reg[2]));
            q_data.data[3] = clsr_pkg::turn_over(buf_reg[3]);
            q_data.data[4] = clsr_pkg::turn_over(clsr_pkg::swap_top(buf_reg[4]));
            q_data.data[5] = clsr_pkg::turn_over(clsr_pkg::swap_top(buf_reg[5]));
        end
        q_data.level = (brightness_level > clsr_pkg::LEVEL_MAX) ? 3'd7 : brightness_level[2:0];
    end

endmodule

// ===== src/clsr_queue.sv =====
// clsr_queue: short FIFO of refresh transactions between front and back.
// Uses clsr_pkg.

module clsr_queue #(
    parameter int DEPTH = clsr_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  clsr_pkg::refresh_t push_data,
    output logic               full,
    output logic               not_empty,
    input  logic               pop,
    output clsr_pkg::refresh_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    clsr_pkg::refresh_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/clsr_back.sv =====
// clsr_back: sequences the nine frames of a refresh transaction into the
// output register. Uses clsr_pkg.

module clsr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  clsr_pkg::refresh_t q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_frame_word,
    output logic [4:0]         m_frame_bits,
    output logic               m_last_frame
);

    logic        valid_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] word_reg;
    logic [4:0]  bits_reg;
    logic        last_reg;
    logic        advance;
    logic [15:0] word_next;
    logic [4:0]  bits_next;
    logic        last_next;
    logic [2:0]  idx;

    assign advance = q_not_empty && (!valid_reg || m_ready);
    assign q_pop   = advance && (cnt_reg == 4'(clsr_pkg::FRAME_COUNT - 1));
    assign idx     = 3'(cnt_reg - 4'd2);

    always_comb begin
        cnt_next  = cnt_reg;
        word_next = 16'h0000;
        bits_next = clsr_pkg::BITS_CMD;
        last_next = 1'b0;
        case (cnt_reg)
            4'd0: word_next = {8'h00, clsr_pkg::FRAME_MODE};
            4'd1: word_next = {8'h00, clsr_pkg::FRAME_DATA_AUTO};
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
                word_next = {q_head.data[idx], clsr_pkg::ADDR_BASE + {4'd0, idx, 1'b0}};
                bits_next = clsr_pkg::BITS_DATA;
            end
            default: begin
                word_next = {8'h00, clsr_pkg::FRAME_DISP_ON | {5'd0, q_head.level}};
                last_next = 1'b1;
            end
        endcase
        if (advance) begin
            cnt_next = q_pop ? 4'd0 : cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= 4'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (advance) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            word_reg <= word_next;
            bits_reg <= bits_next;
            last_reg <= last_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_frame_word = word_reg;
    assign m_frame_bits = bits_reg;
    assign m_last_frame = last_reg;

endmodule

// ===== src/clock_led_segment_refresh_unit.sv =====
// clock_led_segment_refresh_unit: top level, APB registers, front, queue, back.
// Uses clsr_pkg, clsr_front, clsr_queue, clsr_back.
//
//   channel   direction  contents
//   s_*       in         cmd, date_mode, hour/minute/second/month/day values
//   m_*       out        frame_word, frame_bits, last_frame
//   APB       in/out     brightness_level (0x0), flipped_view (0x4)
//
// A load transaction gives no frames.
// A tick gives nine frames, one per cycle while m_ready holds, set by the back-end frame counter.
// Ticks queue (QUEUE_DEPTH deep); s_ready drops only while the queue is full.
// Output stall holds the frame register; reset is synchronous, buffer to dashes.

module clock_led_segment_refresh_unit #(
    parameter int QUEUE_DEPTH = clsr_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic        s_date_mode,
    input  logic [4:0]  s_hour_value,
    input  logic [5:0]  s_minute_value,
    input  logic [5:0]  s_second_value,
    input  logic [3:0]  s_month_value,
    input  logic [4:0]  s_day_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_frame_word,
    output logic [4:0]  m_frame_bits,
    output logic        m_last_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]         brightness_reg;
    logic               flipped_reg;
    logic               q_full, q_not_empty, q_push, q_pop;
    clsr_pkg::refresh_t q_in, q_head;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= 8'd3;
            flipped_reg    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                clsr_pkg::ADDR_BRIGHTNESS: brightness_reg <= pwdata[7:0];
                clsr_pkg::ADDR_FLIPPED:    flipped_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            clsr_pkg::ADDR_BRIGHTNESS: prdata = {24'd0, brightness_reg};
            clsr_pkg::ADDR_FLIPPED:    prdata = {31'd0, flipped_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    clsr_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_date_mode      (s_date_mode),
        .s_hour_value     (s_hour_value),
        .s_minute_value   (s_minute_value),
        .s_second_value   (s_second_value),
        .s_month_value    (s_month_value),
        .s_day_value      (s_day_value),
        .brightness_level (brightness_reg),
        .flipped_view     (flipped_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_in)
    );

    clsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head      (q_head)
    );

    clsr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_word (m_frame_word),
        .m_frame_bits (m_frame_bits),
        .m_last_frame (m_last_frame)
    );

endmodule

// ===== tb/clock_led_segment_refresh_unit_tb.sv =====
// Testbench for clock_led_segment_refresh_unit: load and refresh transactions, APB
// register settings, frame checking against an in-bench display model.
// Depends on clsr_pkg and the unit itself.
`timescale 1ns / 100ps

module clock_led_segment_refresh_unit_tb;

    localparam logic [2:0] BRIGHT_ADDR = {clsr_pkg::ADDR_BRIGHTNESS, 2'b00};
    localparam logic [2:0] FLIP_ADDR   = {clsr_pkg::ADDR_FLIPPED, 2'b00};

    typedef struct packed {
        logic       cmd;
        logic       date_mode;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [3:0] month;
        logic [4:0] day;
    } item_t;

    typedef struct packed {
        logic [15:0] word;
        logic [4:0]  bits;
        logic        last;
    } frame_t;

    class frame_scoreboard;
        logic [7:0] digits [6];
        logic [7:0] brightness;
        logic       flipped;
        frame_t     expected_frames [$];
        int         errors;
        int         frames_checked;

        function new();
            for (int i = 0; i < 6; i++) digits[i] = clsr_pkg::SEG_DASH;
            brightness     = 8'd3;
            flipped        = 1'b0;
            errors         = 0;
            frames_checked = 0;
        endfunction

        function logic [7:0] seg_of(input int d);
            case (d)
                0: return 8'h3f;
                1: return 8'h06;
                2: return 8'h5b;
                3: return 8'h4f;
                4: return 8'h66;
                5: return 8'h6d;
                6: return 8'h7d;
                7: return 8'h07;
                8: return 8'h7f;
                9: return 8'h6f;
                default: return 8'h00;
            endcase
        endfunction

        function logic [7:0] tens_seg(input int v);
            return seg_of((v / 10) % 10);
        endfunction

        function logic [7:0] units_seg(input int v);
            return seg_of(v % 10);
        endfunction

        function logic [7:0] exchange_67(input logic [7:0] v);
            return {v[6], v[7], v[5:0]};
        endfunction

        // upside-down wiring: segment groups 0..2 and 3..5 trade places, 6 and 7 too
        function logic [7:0] invert_bits(input logic [7:0] v);
            return {v[6], v[7], v[2:0], v[5:3]};
        endfunction

        function void add_frame(input logic [15:0] w, input logic [4:0] b, input logic l);
            frame_t f;
            f.word = w;
            f.bits = b;
            f.last = l;
            expected_frames.push_back(f);
        endfunction

        function void set_reg(input logic [2:0] addr, input logic [31:0] v);
            if (addr == BRIGHT_ADDR) brightness = v[7:0];
            else if (addr == FLIP_ADDR) flipped = v[0];
        endfunction

        function logic [31:0] reg_value(input logic [2:0] addr);
            return addr == BRIGHT_ADDR ? 32'(brightness) : 32'(flipped);
        endfunction

        function void note_input(input item_t it);
            logic [7:0] shown [6];
            logic [7:0] lvl;
            if (it.cmd == clsr_pkg::CMD_LOAD) begin
                if (!it.date_mode) begin
                    digits[0] = tens_seg(it.hour);
                    digits[1] = units_seg(it.hour) | clsr_pkg::SEG_DOT;
                    digits[2] = tens_seg(it.minute) | clsr_pkg::SEG_DOT;
                    digits[3] = units_seg(it.minute) | clsr_pkg::SEG_DOT;
                    digits[4] = tens_seg(it.second) | clsr_pkg::SEG_DOT;
                    digits[5] = units_seg(it.second);
                end else begin
                    digits[0] = clsr_pkg::SEG_BLANK;
                    digits[1] = tens_seg(it.month);
                    digits[2] = units_seg(it.month);
                    digits[3] = clsr_pkg::SEG_DASH;
                    digits[4] = tens_seg(it.day);
                    digits[5] = units_seg(it.day);
                end
                return;
            end
            if (!flipped) begin
                shown[0] = exchange_67(digits[5]);
                shown[1] = exchange_67(digits[4]);
                shown[2] = digits[3];
                shown[3] = exchange_67(digits[2]);
                shown[4] = digits[1];
                shown[5] = digits[0];
            end else begin
                shown[0] = invert_bits(digits[0]);
                shown[1] = invert_bits(digits[1]);
                shown[2] = invert_bits(exchange_67(digits[2]));
                shown[3] = invert_bits(digits[3]);
                shown[4] = invert_bits(exchange_67(digits[4]));
                shown[5] = invert_bits(exchange_67(digits[5]));
            end
            add_frame({8'h00, clsr_pkg::FRAME_MODE}, clsr_pkg::BITS_CMD, 1'b0);
            add_frame({8'h00, clsr_pkg::FRAME_DATA_AUTO}, clsr_pkg::BITS_CMD, 1'b0);
            for (int i = 0; i < 6; i++)
                add_frame({shown[i], clsr_pkg::ADDR_BASE + 8'(2 * i)},
                          clsr_pkg::BITS_DATA, 1'b0);
            lvl = brightness > clsr_pkg::LEVEL_MAX ? clsr_pkg::LEVEL_MAX : brightness;
            add_frame({8'h00, clsr_pkg::FRAME_DISP_ON | lvl}, clsr_pkg::BITS_CMD, 1'b1);
        endfunction

        function void check_result(input frame_t got);
            frame_t exp_f;
            if (expected_frames.size() == 0) begin
                $error("frame %h/%0d/%0b with no transaction pending",
                       got.word, got.bits, got.last);
                errors++;
                return;
            end
            exp_f = expected_frames.pop_front();
            frames_checked++;
            if (got.word !== exp_f.word) begin
                $error("frame_word expected %h got %h", exp_f.word, got.word);
                errors++;
            end
            if (got.bits !== exp_f.bits) begin
                $error("frame_bits expected %0d got %0d", exp_f.bits, got.bits);
                errors++;
            end
            if (got.last !== exp_f.last) begin
                $error("last_frame expected %0b got %0b", exp_f.last, got.last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_frames.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic        s_date_mode;
    logic [4:0]  s_hour_value;
    logic [5:0]  s_minute_value;
    logic [5:0]  s_second_value;
    logic [3:0]  s_month_value;
    logic [4:0]  s_day_value;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_frame_word;
    logic [4:0]  m_frame_bits;
    logic        m_last_frame;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb;
    logic quiet;
    int   loads_sent;
    int   ticks_sent;
    int   settings_used;

    clock_led_segment_refresh_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_date_mode    (s_date_mode),
        .s_hour_value   (s_hour_value),
        .s_minute_value (s_minute_value),
        .s_second_value (s_second_value),
        .s_month_value  (s_month_value),
        .s_day_value    (s_day_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_word   (m_frame_word),
        .m_frame_bits   (m_frame_bits),
        .m_last_frame   (m_last_frame),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(2_000_000);
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_frame_word, m_frame_bits, m_last_frame});
    end

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    function automatic item_t mk(input logic c, input logic dm, input int h, input int mi,
                                 input int se, input int mo, input int d);
        item_t it;
        it.cmd       = c;
        it.date_mode = dm;
        it.hour      = 5'(h);
        it.minute    = 6'(mi);
        it.second    = 6'(se);
        it.month     = 4'(mo);
        it.day       = 5'(d);
        return it;
    endfunction

    // mostly in-range values, sometimes anything the field width allows
    function automatic item_t rand_load();
        item_t it;
        it.cmd       = clsr_pkg::CMD_LOAD;
        it.date_mode = 1'($urandom_range(0, 1));
        it.hour      = $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, 23));
        it.minute    = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 59));
        it.second    = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 59));
        it.month     = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 12));
        it.day       = 5'($urandom);
        return it;
    endfunction

    function automatic item_t rand_tick();
        item_t it;
        it           = item_t'(28'($urandom));
        it.cmd       = clsr_pkg::CMD_TICK;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        s_valid        <= 1'b1;
        s_cmd          <= it.cmd;
        s_date_mode    <= it.date_mode;
        s_hour_value   <= it.hour;
        s_minute_value <= it.minute;
        s_second_value <= it.second;
        s_month_value  <= it.month;
        s_day_value    <= it.day;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        if (it.cmd == clsr_pkg::CMD_TICK) ticks_sent++;
        else loads_sent++;
    endtask

    task automatic item_gap();
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // hold the sender until every frame is out, then let a load settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(addr, v);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== sb.reg_value(addr)) begin
            $error("prdata at %h expected %h got %h", addr, sb.reg_value(addr), prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_burst(input int n);
        int k;
        int r;
        k = 0;
        while (k < n) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                send_item(rand_load());
                item_gap();
                send_item(rand_tick());
                k += 2;
            end else if (r < 8) begin
                send_item(rand_tick());
                k++;
            end else begin
                send_item(rand_load());
                k++;
            end
            if (!quiet && $urandom_range(0, 39) == 0) drain();
            else item_gap();
        end
    endtask

    initial begin
        logic [7:0] lvl_set [4];
        logic       flip_set [4];
        logic [7:0] lvl;
        logic       flip;
        sb = new();
        quiet = 1'b0;
        loads_sent = 0;
        ticks_sent = 0;
        settings_used = 1;
        lvl_set  = '{8'd255, 8'd7, 8'd8, 8'd0};
        flip_set = '{1'b1, 1'b0, 1'b1, 1'b0};
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = clsr_pkg::CMD_LOAD;
        s_date_mode    = 1'b0;
        s_hour_value   = '0;
        s_minute_value = '0;
        s_second_value = '0;
        s_month_value  = '0;
        s_day_value    = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset buffer of dashes, time and date extremes, out-of-range values
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_LOAD, 0, 0, 0, 0, 15, 31));
        send_item(mk(clsr_pkg::CMD_TICK, 1, 31, 63, 63, 15, 31));
        send_item(mk(clsr_pkg::CMD_LOAD, 0, 23, 59, 59, 0, 0));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_LOAD, 0, 31, 63, 63, 0, 0));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_LOAD, 1, 31, 63, 63, 0, 0));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_LOAD, 1, 0, 0, 0, 12, 31));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_LOAD, 1, 0, 0, 0, 15, 31));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_LOAD, 0, 10, 20, 9, 0, 0));
        send_item(mk(clsr_pkg::CMD_LOAD, 1, 5, 5, 5, 1, 1));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk(clsr_pkg::CMD_LOAD, 0, 19, 48, 37, 0, 0));
        send_item(mk(clsr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        drain();
        apb_read_check(BRIGHT_ADDR);
        apb_read_check(FLIP_ADDR);

        for (int p = 0; p < 6; p++) begin
            lvl  = p < 4 ? lvl_set[p] : 8'($urandom_range(0, 255));
            flip = p < 4 ? flip_set[p] : 1'($urandom_range(0, 1));
            apb_write(BRIGHT_ADDR, 32'(lvl));
            apb_write(FLIP_ADDR, 32'(flip));
            apb_read_check(BRIGHT_ADDR);
            apb_read_check(FLIP_ADDR);
            settings_used++;
            quiet = (p == 5);
            random_burst(60);
            drain();
        end
        repeat (20) @(posedge aclk);

        if (sb.outstanding() != 0) begin
            $error("%0d frames never arrived", sb.outstanding());
            sb.errors++;
        end
        $display("Ran %0d loads and %0d refresh ticks under %0d register settings,",
                 loads_sent, ticks_sent, settings_used);
        $display("%0d frames compared, %0d mismatches", sb.frames_checked, sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/clsr_pkg.sv
src/clsr_front.sv
src/clsr_queue.sv
src/clsr_back.sv
src/clock_led_segment_refresh_unit.sv
tb/clock_led_segment_refresh_unit_tb.sv
